### hdl/docq_pkg.sv
// ----------------------------------------------------------------------------
// docq_pkg
// Shared constants, types and state codes for the deadline-ordered queue.
// ----------------------------------------------------------------------------
package docq_pkg;

  localparam int CAPACITY     = 64;
  localparam int COMMAND_BITS = 64;
  localparam int ADDR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DEPTH        = 1 << ADDR_W;
  localparam int COUNT_W      = $clog2(CAPACITY + 1);
  localparam int ENTRY_W      = 64 + COMMAND_BITS;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_PROCESS  = 1'b1;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_CMD = 1'b1;

  typedef struct packed {
    logic [63:0]             deadline;
    logic [COMMAND_BITS-1:0] command;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_FIN,
    ST_PRC_FIRST,
    ST_PRC_LOOK,
    ST_PRC_WAIT,
    ST_OUT_LAST
  } state_t;

endpackage

### hdl/deadline_ordered_command_queue_core.sv
// ----------------------------------------------------------------------------
// deadline_ordered_command_queue_core
// Earliest-deadline-first command queue kept sorted in a circular RAM.
// ----------------------------------------------------------------------------
// Input items (in_valid / in_stall) are either a schedule (in_op = 0) carrying
// a deadline and command word, or a process (in_op = 1) carrying a block
// start and length. A schedule yields one acknowledgement item with
// out_accepted telling whether the command was stored (refused when full).
// A process yields every stored command with deadline below the saturated
// block end, in deadline order (equal deadlines in insertion order), the
// final one flagged by out_last; nothing when none is due.
// Entries sit sorted in one RAM used as a ring: release advances the head,
// insertion walks down from the tail shifting one entry per cycle.
// Insert: reads the tail, shifts each entry with a later deadline up one
// place, then writes the new entry; empty or full queues ack from idle.
// Process: checks the head entry, then presents each released item while
// the lookahead loop reads the next entry from the RAM.
// One item is in work at a time; in_stall is high while busy.
// Reset (rst_n low, synchronous) empties the queue; RAM contents need no
// clearing. While out_stall is high the result holds and work pauses.
// ----------------------------------------------------------------------------
module deadline_ordered_command_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [63:0] in_deadline,
  input  logic [63:0] in_command_word,
  input  logic [63:0] in_block_start,
  input  logic [15:0] in_block_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_accepted,
  output logic [63:0] out_due_command,
  output logic [63:0] out_due_deadline,
  output logic        out_last
);

  localparam int AW = docq_pkg::ADDR_W;
  localparam int CW = docq_pkg::COUNT_W;

  docq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  docq_pkg::entry_t new_r, new_nxt;
  docq_pkg::entry_t cur_r, cur_nxt;
  logic [63:0]      end_r, end_nxt;

  logic             ov_r, ov_nxt;
  logic             okind_r, okind_nxt;
  logic             oacc_r, oacc_nxt;
  docq_pkg::entry_t oent_r, oent_nxt;
  logic             olast_r, olast_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  docq_pkg::entry_t wdata, rdata;
  logic [64:0]      end_sum;
  logic             out_take;
  logic             due;
  logic [CW-1:0]    pos_dec;

  docq_ram #(
    .WIDTH(docq_pkg::ENTRY_W),
    .DEPTH(docq_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign end_sum  = {1'b0, in_block_start} + {49'd0, in_block_len};
  assign out_take = ov_r && !out_stall;
  assign due      = rdata.deadline < end_r;
  assign pos_dec  = pos_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= docq_pkg::ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    new_r   <= new_nxt;
    cur_r   <= cur_nxt;
    end_r   <= end_nxt;
    okind_r <= okind_nxt;
    oacc_r  <= oacc_nxt;
    oent_r  <= oent_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    new_nxt   = new_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    ov_nxt    = ov_r;
    okind_nxt = okind_r;
    oacc_nxt  = oacc_r;
    oent_nxt  = oent_r;
    olast_nxt = olast_r;
    we        = 1'b0;
    waddr     = head_r + pos_r[AW-1:0];
    wdata     = new_r;
    raddr     = head_r;
    unique case (state_r)
      docq_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == docq_pkg::OP_SCHEDULE) begin
            new_nxt.deadline = in_deadline;
            new_nxt.command  = in_command_word[docq_pkg::COMMAND_BITS-1:0];
            oent_nxt  = '0;
            okind_nxt = docq_pkg::KIND_ACK;
            olast_nxt = 1'b1;
            if (count_r >= CW'(docq_pkg::CAPACITY)) begin
              oacc_nxt  = 1'b0;
              ov_nxt    = 1'b1;
              state_nxt = docq_pkg::ST_OUT_LAST;
            end else if (count_r == '0) begin
              we        = 1'b1;
              waddr     = head_r;
              wdata     = new_nxt;
              count_nxt = count_r + CW'(1);
              oacc_nxt  = 1'b1;
              ov_nxt    = 1'b1;
              state_nxt = docq_pkg::ST_OUT_LAST;
            end else begin
              pos_nxt   = count_r;
              raddr     = head_r + count_r[AW-1:0] - AW'(1);
              state_nxt = docq_pkg::ST_INS_CMP;
            end
          end else begin
            end_nxt = end_sum[64] ? '1 : end_sum[63:0];
            if (count_r != '0) begin
              state_nxt = docq_pkg::ST_PRC_FIRST;
            end
          end
        end
      end
      docq_pkg::ST_INS_CMP: begin
        if (rdata.deadline > new_r.deadline) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_nxt = pos_dec;
          raddr   = head_r + pos_dec[AW-1:0] - AW'(1);
          if (pos_dec == '0) begin
            state_nxt = docq_pkg::ST_INS_FIN;
          end
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
          oacc_nxt  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = docq_pkg::ST_OUT_LAST;
        end
      end
      docq_pkg::ST_INS_FIN: begin
        we        = 1'b1;
        count_nxt = count_r + CW'(1);
        oacc_nxt  = 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = docq_pkg::ST_OUT_LAST;
      end
      docq_pkg::ST_PRC_FIRST: begin
        if (!due) begin
          state_nxt = docq_pkg::ST_IDLE;
        end else begin
          cur_nxt   = rdata;
          head_nxt  = head_r + AW'(1);
          count_nxt = count_r - CW'(1);
          raddr     = head_r + AW'(1);
          if (count_nxt == '0) begin
            okind_nxt = docq_pkg::KIND_CMD;
            oacc_nxt  = 1'b1;
            oent_nxt  = rdata;
            olast_nxt = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = docq_pkg::ST_OUT_LAST;
          end else begin
            state_nxt = docq_pkg::ST_PRC_LOOK;
          end
        end
      end
      docq_pkg::ST_PRC_LOOK: begin
        okind_nxt = docq_pkg::KIND_CMD;
        oacc_nxt  = 1'b1;
        oent_nxt  = cur_r;
        ov_nxt    = 1'b1;
        olast_nxt = !due;
        cur_nxt   = rdata;
        state_nxt = due ? docq_pkg::ST_PRC_WAIT : docq_pkg::ST_OUT_LAST;
      end
      docq_pkg::ST_PRC_WAIT: begin
        if (out_take) begin
          ov_nxt    = 1'b0;
          head_nxt  = head_r + AW'(1);
          count_nxt = count_r - CW'(1);
          raddr     = head_r + AW'(1);
          if (count_nxt == '0) begin
            oent_nxt  = cur_r;
            olast_nxt = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = docq_pkg::ST_OUT_LAST;
          end else begin
            state_nxt = docq_pkg::ST_PRC_LOOK;
          end
        end
      end
      docq_pkg::ST_OUT_LAST: begin
        if (out_take) begin
          ov_nxt    = 1'b0;
          state_nxt = docq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = docq_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall         = (state_r != docq_pkg::ST_IDLE);
  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_accepted     = oacc_r;
  assign out_due_command  = 64'(oent_r.command);
  assign out_due_deadline = oent_r.deadline;
  assign out_last         = olast_r;

endmodule

### hdl/docq_ram.sv
// ----------------------------------------------------------------------------
// docq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module docq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/deadline_ordered_command_queue_core_test.sv
// ----------------------------------------------------------------------------
// deadline_ordered_command_queue_core_test
// Self-checking bench for the earliest-deadline-first command queue: a sorted
// queue model predicts acks and released commands, a monitor compares each
// output item against the oldest prediction, under random bursts and stalls.
// ----------------------------------------------------------------------------
module deadline_ordered_command_queue_core_test;

  typedef struct {
    logic        op;
    logic [63:0] deadline;
    logic [63:0] command_word;
    logic [63:0] block_start;
    logic [15:0] block_len;
  } req_t;

  typedef struct {
    logic        kind;
    logic        accepted;
    logic [63:0] due_command;
    logic [63:0] due_deadline;
    logic        last;
  } rsp_t;

  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [63:0] in_deadline = '0;
  logic [63:0] in_command_word = '0;
  logic [63:0] in_block_start = '0;
  logic [15:0] in_block_len = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic        out_accepted;
  logic [63:0] out_due_command;
  logic [63:0] out_due_deadline;
  logic        out_last;

  deadline_ordered_command_queue_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t        pending_q[$];
  rsp_t        expected_q[$];
  logic [63:0] held_deadline[$];
  logic [63:0] held_command[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_for_drain = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_phase = 0;

  function automatic void add_req(req_t r);
    pending_q = {pending_q, r};
  endfunction

  function automatic void add_rsp(rsp_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic void predict_queue(req_t r);
    rsp_t rs;
    int   pos;
    int   n;
    logic [63:0] blk_end;
    if (r.op == docq_pkg::OP_SCHEDULE) begin
      rs = '{docq_pkg::KIND_ACK, 1'b0, 64'd0, 64'd0, 1'b1};
      if (held_deadline.size() < docq_pkg::CAPACITY) begin
        pos = held_deadline.size();
        while (pos > 0 && held_deadline[pos-1] > r.deadline) pos--;
        held_deadline.insert(pos, r.deadline);
        held_command.insert(pos, r.command_word);
        rs.accepted = 1'b1;
      end
      add_rsp(rs);
    end else begin
      blk_end = r.block_start + r.block_len;
      if (blk_end < r.block_start) blk_end = MAX64;
      n = 0;
      while (n < held_deadline.size() && held_deadline[n] < blk_end) n++;
      for (int i = 0; i < n; i++) begin
        rs = '{docq_pkg::KIND_CMD, 1'b1, held_command[0], held_deadline[0], i == n - 1};
        add_rsp(rs);
        void'(held_deadline.pop_front());
        void'(held_command.pop_front());
      end
    end
  endfunction

  function automatic req_t sched(logic [63:0] dl, logic [63:0] cw);
    sched = '{docq_pkg::OP_SCHEDULE, dl, cw, {$urandom, $urandom}, 16'($urandom)};
  endfunction

  function automatic req_t blk(logic [63:0] st, logic [15:0] ln);
    blk = '{docq_pkg::OP_PROCESS, {$urandom, $urandom}, {$urandom, $urandom}, st, ln};
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_queue('{in_op, in_deadline, in_command_word, in_block_start,
                        in_block_len});
        void'(pending_q.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (!(in_valid && in_stall)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (hold_for_drain && expected_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid        <= 1'b1;
          in_op           <= pending_q[0].op;
          in_deadline     <= pending_q[0].deadline;
          in_command_word <= pending_q[0].command_word;
          in_block_start  <= pending_q[0].block_start;
          in_block_len    <= pending_q[0].block_len;
        end
      end
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item kind=%0b cmd=%h dl=%h", $time, out_kind,
                   out_due_command, out_due_deadline);
          errors++;
        end else begin
          if (out_kind !== expected_q[0].kind || out_accepted !== expected_q[0].accepted
              || out_due_command !== expected_q[0].due_command
              || out_due_deadline !== expected_q[0].due_deadline
              || out_last !== expected_q[0].last) begin
            $display("%0t: expected k=%0b a=%0b c=%h d=%h l=%0b got k=%0b a=%0b c=%h d=%h l=%0b",
                     $time, expected_q[0].kind, expected_q[0].accepted,
                     expected_q[0].due_command, expected_q[0].due_deadline,
                     expected_q[0].last, out_kind, out_accepted, out_due_command,
                     out_due_deadline, out_last);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 16) out_stall <= 1'b0;
      else if (stall_phase < 40) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] base;
    logic [63:0] dl;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    add_req(blk(64'd0, 16'd0));
    add_req(sched(MAX64, MAX64));
    add_req(sched(64'd0, 64'd0));
    add_req(sched(64'd5, 64'hAAAA_5555_AAAA_5555));
    add_req(sched(64'd5, 64'h5555_AAAA_5555_AAAA));
    add_req(sched(64'h8000_0000_0000_0000, 64'h1));
    add_req(blk(64'd5, 16'd0));
    add_req(blk(64'd0, 16'hFFFF));
    add_req(blk(MAX64 - 64'd3, 16'hFFFF));
    for (int i = 0; i < 66; i++)
      add_req(sched({$urandom, $urandom}, {$urandom, $urandom}));
    add_req(blk(MAX64, 16'hFFFF));
    add_req(blk(MAX64 - 64'd1, 16'd1));
    while (pending_q.size() != 0) @(posedge clk);
    hold_for_drain = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    hold_for_drain = 1'b0;
    // random: sequences around a moving time base
    base = {$urandom, $urandom} >> $urandom_range(0, 63);
    for (int n = 0; n < 130; n++) begin
      case ($urandom_range(0, 9))
        0: add_req(sched({$urandom, $urandom}, {$urandom, $urandom}));
        1, 2: begin
          add_req(blk(base, 16'($urandom_range(0, 600))));
          base = base + $urandom_range(0, 700);
        end
        3: add_req(blk({$urandom, $urandom}, 16'($urandom)));
        default: begin
          dl = base + $urandom_range(0, 1500);
          if ($urandom_range(0, 5) == 0) dl = base + $urandom_range(0, 3);
          add_req(sched(dl, {$urandom, $urandom}));
        end
      endcase
    end
    add_req(blk(MAX64, 16'hFFFF));
    while (pending_q.size() != 0) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/docq_pkg.sv
hdl/docq_ram.sv
hdl/deadline_ordered_command_queue_core.sv
bench/deadline_ordered_command_queue_core_test.sv
